>>> rtl/bpa_pkg.sv
// Package of the buddy page allocator: item structs, operation codes,
// controller states and the command and status bundles.
// Depends on nothing; bpa_ctrl, bpa_dp and the top level import it.
package bpa_pkg;

   localparam int OP_W    = 2;
   localparam int SIZE_W  = 11;
   localparam int PAGE_W  = 10;
   localparam int COUNT_W = 11;

   localparam logic [OP_W-1:0] OP_REBUILD = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SIZE_W-1:0] size;
      logic [PAGE_W-1:0] page_index;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [PAGE_W-1:0]  start_page;
      logic [COUNT_W-1:0] free_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DESC,
      ST_ASC,
      ST_SWEEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic desc_step;
      logic root_take;
      logic asc_step;
      logic sweep_step;
      logic sweep_full;
      logic set_ok;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic pre_fail;
      logic root_hit;
      logic desc_stop;
      logic desc_fail;
      logic asc_last;
      logic sweep_last;
   } stat_type;

endpackage

>>> rtl/bpa_ram.sv
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data <= mem_ff[rd_a_addr];
      rd_b_data <= mem_ff[rd_b_addr];
   end

endmodule

>>> rtl/bpa_ctrl.sv
// Controller of the buddy page allocator: sequences clearing, descent,
// ascent, rebuild sweep and result hand-off. Depends on bpa_pkg.
module bpa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [bpa_pkg::OP_W-1:0] req_op,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  bpa_pkg::stat_type        stat,
   output bpa_pkg::cmd_type         cmd
);
   import bpa_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_REBUILD) begin
                  state_in = ST_SWEEP;
               end else if (req_op == OP_ALLOC || req_op == OP_FREE) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CHECK: begin
            priority if (stat.pre_fail)  state_in = ST_DONE;
            else if (stat.root_hit)      state_in = ST_ASC;
            else if (stat.desc_fail)     state_in = ST_DONE;
            else if (stat.desc_stop)     state_in = ST_ASC;
            else                         state_in = ST_DESC;
         end
         ST_DESC: begin
            priority if (stat.desc_fail) state_in = ST_DONE;
            else if (stat.desc_stop)     state_in = ST_ASC;
            else                         state_in = ST_DESC;
         end
         ST_ASC: begin
            if (stat.asc_last) state_in = ST_DONE;
         end
         ST_SWEEP: begin
            if (stat.sweep_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_step = 1'b1;
            cmd.sweep_full = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_CHECK: begin
            if (!stat.pre_fail) begin
               if (stat.root_hit) begin
                  cmd.root_take = 1'b1;
                  cmd.set_ok    = 1'b1;
               end else begin
                  cmd.desc_step = 1'b1;
                  cmd.set_ok    = !stat.desc_fail && stat.desc_stop;
               end
            end
         end
         ST_DESC: begin
            cmd.desc_step = 1'b1;
            cmd.set_ok    = !stat.desc_fail && stat.desc_stop;
         end
         ST_ASC: begin
            cmd.asc_step = 1'b1;
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            cmd.set_ok     = stat.sweep_last;
         end
         ST_DONE: begin
            cmd.load_rsp = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over one not yet taken");

   a_asc_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ASC && stat.asc_last) |=> (state_ff == ST_DONE))
      else $error("ascent did not end after the root write");

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff != ST_IDLE && !req_ready))
      else $error("accepted item did not leave idle");

endmodule

>>> rtl/bpa_dp.sv
// Datapath of the buddy page allocator: node memory, path registers,
// rebuild sweep counters, free count and result register.
// Depends on bpa_pkg and bpa_ram.
module bpa_dp #(
   parameter int LEAVES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bpa_pkg::req_type               req_data,
   input  logic                           csr_wr_en,
   input  logic [bpa_pkg::COUNT_W-1:0]    csr_wr_data,
   input  bpa_pkg::cmd_type               cmd,
   output bpa_pkg::stat_type              stat,
   output bpa_pkg::rsp_type               rsp_data
);
   import bpa_pkg::*;

   localparam int LEVELS = $clog2(LEAVES);
   localparam int RUNW   = LEVELS + 1;
   localparam int NODES  = 2 * LEAVES - 1;
   localparam int AW     = $clog2(NODES);
   localparam int LVW    = $clog2(LEVELS + 1);
   localparam int SIBW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CW     = ((RUNW > COUNT_W) ? RUNW : COUNT_W) + 1;
   localparam logic [RUNW-1:0] LEAVES_R = RUNW'(LEAVES);
   localparam logic [CW-1:0]   LEAVES_C = CW'(LEAVES);
   localparam logic [AW-1:0]   LAST_IDX = AW'(NODES - 1);

   req_type              req_ff;
   logic [COUNT_W-1:0]   usable_ff;
   logic [RUNW-1:0]      free_ff, free_in;
   logic [AW-1:0]        idx_ff;
   logic [LEVELS-1:0]    lo_ff;
   logic [RUNW-1:0]      span_ff;
   logic [LVW-1:0]       lvl_ff;
   logic [RUNW-1:0]      sib_ff [LEVELS];
   logic [RUNW-1:0]      cur_run_ff;
   logic                 cur_alloc_ff;
   logic                 ok_ff;
   logic [PAGE_W-1:0]    start_ff;
   logic [RUNW-1:0]      root_run_ff;
   logic                 root_alloc_ff;
   logic [AW-1:0]        sw_idx_ff;
   logic [LEVELS-1:0]    sw_lo_ff;
   logic [RUNW-1:0]      sw_span_ff;
   rsp_type              rsp_ff;

   logic [RUNW:0]        rd_a_data, rd_b_data;
   logic [AW-1:0]        rd_a_addr, rd_b_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [RUNW:0]        wr_data;

   // Descent decode.
   logic [RUNW-1:0] l_run, r_run, half;
   logic            l_alc, r_alc, is_leaf, is_alloc;
   logic            a_left, a_right, f_right, take_right, child_alc, move;
   logic [AW:0]     cidx;
   logic [AW-1:0]   nidx;
   logic [RUNW-1:0] nspan;
   logic [AW:0]     naddr;

   assign l_run    = rd_a_data[RUNW-1:0];
   assign l_alc    = rd_a_data[RUNW];
   assign r_run    = rd_b_data[RUNW-1:0];
   assign r_alc    = rd_b_data[RUNW];
   assign half     = span_ff >> 1;
   assign is_leaf  = (span_ff == RUNW'(1));
   assign is_alloc = (req_ff.op == OP_ALLOC);
   assign a_left   = CW'(l_run) >= CW'(req_ff.size);
   assign a_right  = CW'(r_run) >= CW'(req_ff.size);
   assign f_right  = CW'(req_ff.page_index) >= (CW'(lo_ff) + CW'(half));
   assign take_right = is_alloc ? !a_left : f_right;
   assign child_alc  = take_right ? r_alc : l_alc;

   assign stat.desc_fail = !is_alloc && is_leaf;
   assign stat.desc_stop = is_alloc ? (is_leaf || !(a_left || a_right)) : child_alc;
   assign move = cmd.desc_step && !stat.desc_fail && !(is_alloc && stat.desc_stop);

   assign cidx  = {idx_ff, 1'b0} + (take_right ? (AW+1)'(2) : (AW+1)'(1));
   assign nidx  = cmd.start ? '0 : (move ? cidx[AW-1:0] : idx_ff);
   assign nspan = cmd.start ? LEAVES_R : (move ? half : span_ff);
   assign naddr = {nidx, 1'b0} + (AW+1)'(1);

   always_comb begin
      if (nspan >= RUNW'(2)) begin
         rd_a_addr = naddr[AW-1:0];
         rd_b_addr = naddr[AW-1:0] + AW'(1);
      end else begin
         rd_a_addr = '0;
         rd_b_addr = '0;
      end
   end

   // Pre-checks against the item and the root shadow.
   assign stat.pre_fail = is_alloc
      ? ((req_ff.size == '0) || (CW'(req_ff.size) > CW'(free_ff))
         || (CW'(req_ff.size) > CW'(root_run_ff)))
      : ((CW'(req_ff.page_index) >= CW'(usable_ff))
         || (CW'(req_ff.page_index) >= LEAVES_C));
   assign stat.root_hit = !is_alloc && root_alloc_ff;

   // Ascent: combine the path node with the sibling saved on the way down.
   logic [LVW-1:0]  lvl_dec;
   logic [RUNW-1:0] sib_sel, lrun, rrun, span2, mx, up_run;
   logic [RUNW:0]   sum;
   logic [AW-1:0]   parent;

   assign lvl_dec = lvl_ff - LVW'(1);
   assign sib_sel = sib_ff[lvl_dec[SIBW-1:0]];
   assign lrun    = idx_ff[0] ? cur_run_ff : sib_sel;
   assign rrun    = idx_ff[0] ? sib_sel : cur_run_ff;
   assign span2   = {span_ff[RUNW-2:0], 1'b0};
   assign sum     = (RUNW+1)'(lrun) + (RUNW+1)'(rrun);
   assign mx      = (lrun > rrun) ? lrun : rrun;
   assign up_run  = (!is_alloc && sum == (RUNW+1)'(span2)) ? span2 : mx;
   assign parent  = AW'((idx_ff - AW'(1)) >> 1);
   assign stat.asc_last = (idx_ff == '0);

   // Rebuild sweep: each node's value follows from its range and the usable count.
   logic [CW-1:0]   n_eff, lo_w, sp_w, end_w, par_lo, diff;
   logic            full, beyond, par_ok;
   logic [RUNW-1:0] pw;
   logic [RUNW:0]   sw_word;

   always_comb begin
      if (cmd.sweep_full || CW'(usable_ff) > LEAVES_C) begin
         n_eff = LEAVES_C;
      end else begin
         n_eff = CW'(usable_ff);
      end
      lo_w   = CW'(sw_lo_ff);
      sp_w   = CW'(sw_span_ff);
      end_w  = lo_w + sp_w;
      full   = end_w <= n_eff;
      beyond = lo_w >= n_eff;
      par_lo = lo_w & ~((sp_w << 1) - CW'(1));
      par_ok = (sw_idx_ff == '0) || (par_lo < n_eff);
      diff   = n_eff - lo_w;
      pw     = '0;
      for (int i = 0; i < RUNW; i++) begin
         if (diff[i]) pw = RUNW'(1) << i;
      end
      priority if (full || (beyond && !par_ok)) sw_word = {1'b0, sw_span_ff};
      else if (beyond)                          sw_word = {1'b1, RUNW'(0)};
      else                                      sw_word = {1'b0, pw};
   end
   assign stat.sweep_last = (sw_idx_ff == LAST_IDX);

   assign wr_en   = cmd.asc_step || cmd.sweep_step;
   assign wr_addr = cmd.sweep_step ? sw_idx_ff : idx_ff;
   assign wr_data = cmd.sweep_step ? sw_word : {cur_alloc_ff, cur_run_ff};

   bpa_ram #(
      .WIDTH(RUNW + 1),
      .DEPTH(NODES)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_a_addr(rd_a_addr),
      .rd_a_data(rd_a_data),
      .rd_b_addr(rd_b_addr),
      .rd_b_data(rd_b_data)
   );

   // Free count after the item.
   logic [CW-1:0] fsum;
   assign fsum = CW'(free_ff) + CW'(req_ff.size);
   always_comb begin
      free_in = free_ff;
      unique case (req_ff.op)
         OP_REBUILD: free_in = RUNW'(n_eff);
         OP_ALLOC:   if (ok_ff) free_in = RUNW'(CW'(free_ff) - CW'(req_ff.size));
         OP_FREE:    if (ok_ff) free_in = (fsum > LEAVES_C) ? LEAVES_R : RUNW'(fsum);
         default:    free_in = free_ff;
      endcase
   end

   logic [CW-1:0] lo_c, free_c;
   assign lo_c   = CW'(lo_ff);
   assign free_c = CW'(free_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff     <= COUNT_W'(1024);
         free_ff       <= LEAVES_R;
         sw_idx_ff     <= '0;
         sw_lo_ff      <= '0;
         sw_span_ff    <= LEAVES_R;
         root_run_ff   <= LEAVES_R;
         root_alloc_ff <= 1'b0;
         ok_ff         <= 1'b0;
      end else begin
         if (csr_wr_en) usable_ff <= csr_wr_data;
         if (cmd.sweep_step) begin
            if (stat.sweep_last) begin
               sw_idx_ff  <= '0;
               sw_lo_ff   <= '0;
               sw_span_ff <= LEAVES_R;
            end else begin
               sw_idx_ff <= sw_idx_ff + AW'(1);
               if (end_w == LEAVES_C) begin
                  sw_lo_ff   <= '0;
                  sw_span_ff <= sw_span_ff >> 1;
               end else begin
                  sw_lo_ff <= end_w[LEVELS-1:0];
               end
            end
         end
         if (wr_en && wr_addr == '0) begin
            root_run_ff   <= wr_data[RUNW-1:0];
            root_alloc_ff <= wr_data[RUNW];
         end
         if (cmd.start) begin
            ok_ff <= 1'b0;
         end else if (cmd.set_ok) begin
            ok_ff <= 1'b1;
         end
         if (cmd.load_rsp) free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff   <= req_data;
         idx_ff   <= '0;
         lo_ff    <= '0;
         span_ff  <= LEAVES_R;
         lvl_ff   <= '0;
         start_ff <= '0;
      end else if (cmd.root_take) begin
         cur_run_ff   <= LEAVES_R;
         cur_alloc_ff <= 1'b0;
      end else if (cmd.desc_step) begin
         if (is_alloc && stat.desc_stop) begin
            cur_run_ff   <= '0;
            cur_alloc_ff <= 1'b1;
            start_ff     <= lo_c[PAGE_W-1:0];
         end else if (move) begin
            sib_ff[lvl_ff[SIBW-1:0]] <= take_right ? l_run : r_run;
            idx_ff  <= cidx[AW-1:0];
            lo_ff   <= take_right ? lo_ff + half[LEVELS-1:0] : lo_ff;
            span_ff <= half;
            lvl_ff  <= lvl_ff + LVW'(1);
            if (stat.desc_stop) begin
               cur_run_ff   <= half;
               cur_alloc_ff <= 1'b0;
            end
         end
      end else if (cmd.asc_step && !stat.asc_last) begin
         cur_run_ff   <= up_run;
         cur_alloc_ff <= 1'b0;
         idx_ff       <= parent;
         span_ff      <= span2;
         lvl_ff       <= lvl_dec;
      end
      if (cmd.load_rsp) begin
         rsp_ff.ok         <= ok_ff;
         rsp_ff.start_page <= start_ff;
         rsp_ff.free_count <= free_c[COUNT_W-1:0];
      end
   end

   assign rsp_data = rsp_ff;

   a_move_inner: assert property (@(posedge clock) disable iff (reset)
      move |-> (span_ff >= RUNW'(2)))
      else $error("descent stepped below a leaf");

   a_asc_root_unmarked: assert property (@(posedge clock) disable iff (reset)
      (cmd.asc_step && !stat.asc_last) |=> !cur_alloc_ff)
      else $error("ancestor written as allocated");

   a_sweep_wrap: assert property (@(posedge clock) disable iff (reset)
      (cmd.sweep_step && stat.sweep_last) |=> (sw_idx_ff == '0))
      else $error("sweep counter did not wrap");

endmodule

>>> rtl/buddy_page_allocator.sv
// Top level of the buddy page allocator: binds controller and datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_dp (which holds bpa_ram).
//
//   Channel   Direction  Ports                          Moves
//   req       in         req_valid/req_ready/req_data   one operation item
//   rsp       out        rsp_valid/rsp_ready/rsp_data   one result item per request
//   csr       in         csr_wr_en/csr_wr_data          usable_pages register
//
// An allocate or free item passes a check state, a descent that reads both
// children of a node at once from the node memory, and an ascent with one
// node memory write per level back up. A rebuild item sweeps every node.
// After reset a clearing pass writes every node of the tree; no item
// is accepted meanwhile, though configuration writes are taken.
// The result sits in an output register, so a stalled result channel holds
// a finished item while the next request is already accepted and worked on.
module buddy_page_allocator #(
   parameter int LEAVES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bpa_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bpa_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [bpa_pkg::COUNT_W-1:0]   csr_wr_data
);
   import bpa_pkg::*;

   // The controller sees only the opcode of the waiting item, the handshakes and
   // the datapath status; the datapath does all arithmetic and memory work.
   cmd_type  cmd;
   stat_type stat;

   bpa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_op   (req_data.op),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   // The datapath keeps a shadow of the root node so the allocation check
   // and the free of a whole-tree block need no memory read.
   bpa_dp #(
      .LEAVES(LEAVES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_data   (rsp_data)
   );

endmodule
